// ===== src/rgbcf_pkg.sv =====
// Shared types and constants for the RGB to color filter bit plane block.
`default_nettype none

package rgbcf_pkg;

    localparam int unsigned MAX_ROW_PIXELS_DEF = 4096;
    localparam int unsigned MIN_ROW_PIXELS     = 8;
    localparam int unsigned ROW_WIDTH_W        = 13;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd1600;
    localparam int unsigned COL_W              = 9;
    localparam int unsigned PLANES             = 4;
    localparam int unsigned CHANNELS           = 3;
    localparam int unsigned GROUP_PIX          = 3;
    localparam int unsigned QUEUE_DEPTH        = 2;

    // floor(x / 3) == (x * 683) >> 11 for x <= 765
    localparam logic [9:0] RECIP3 = 10'd683;

    localparam logic [1:0] PHASE_LAST = 2'd2;

    // sub-pixel masks, [channel][row phase]; bit 2 is the leftmost pixel
    localparam logic [2:0] SUB_MASK [CHANNELS][GROUP_PIX] = '{
        '{3'd2, 3'd1, 3'd4},
        '{3'd1, 3'd4, 3'd2},
        '{3'd4, 3'd2, 3'd1}
    };

    typedef struct packed {
        logic [PLANES-1:0][2:0] grp;
        logic [2:0]             offset;
        logic                   fill;
        logic [COL_W-1:0]       fill_col;
        logic                   fill_done;
        logic                   row_end;
        logic                   partial;
        logic [COL_W-1:0]       partial_col;
    } group_t;

endpackage

`default_nettype wire

// ===== src/rgbcf_front.sv =====
// Front end: channel levels, plane bits and row position bookkeeping per group.
`default_nettype none

module rgbcf_front #(
    parameter int unsigned MAX_ROW_PIXELS = rgbcf_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [7:0]                          red_a,
    input  logic [7:0]                          green_a,
    input  logic [7:0]                          blue_a,
    input  logic [7:0]                          red_b,
    input  logic [7:0]                          green_b,
    input  logic [7:0]                          blue_b,
    input  logic [7:0]                          red_c,
    input  logic [7:0]                          green_c,
    input  logic [7:0]                          blue_c,
    input  logic [rgbcf_pkg::ROW_WIDTH_W-1:0]   row_width,
    output rgbcf_pkg::group_t                   group
);
    import rgbcf_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_ROW_PIXELS + GROUP_PIX);

    function automatic logic [COL_W-1:0] col_of(input logic [POS_W-1:0] pos);
        logic [POS_W+COL_W-1:0] wide;
        wide = {{COL_W{1'b0}}, pos} >> 3;
        return wide[COL_W-1:0];
    endfunction

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;

    logic [1:0]             phase;
    logic [9:0]             sum  [CHANNELS];
    logic [19:0]            prod [CHANNELS];
    logic [3:0]             inv  [CHANNELS];
    logic [PLANES-1:0][2:0] grp_raw;
    logic [POS_W-1:0]       w;
    logic [POS_W-1:0]       pos_i [GROUP_PIX];
    logic [GROUP_PIX-1:0]   in_row;
    logic [POS_W:0]         end_pos;
    logic [POS_W:0]         next_pos;
    logic [POS_W-1:0]       e;

    always_comb
    begin
        phase = (phase_reg > PHASE_LAST) ? 2'd0 : phase_reg;

        sum[0] = {2'b0, red_a}   + {2'b0, red_b}   + {2'b0, red_c};
        sum[1] = {2'b0, green_a} + {2'b0, green_b} + {2'b0, green_c};
        sum[2] = {2'b0, blue_a}  + {2'b0, blue_b}  + {2'b0, blue_c};
        for (int c = 0; c < CHANNELS; c++)
        begin
            prod[c] = 20'(sum[c]) * 20'(RECIP3);
            inv[c]  = ~prod[c][18:15];
        end

        for (int p = 0; p < PLANES; p++)
        begin
            grp_raw[p] = 3'd0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (inv[c][p])
                begin
                    grp_raw[p] = grp_raw[p] | SUB_MASK[c][phase];
                end
            end
        end

        if (row_width < ROW_WIDTH_W'(MIN_ROW_PIXELS))
        begin
            w = POS_W'(MIN_ROW_PIXELS);
        end
        else if (32'(row_width) > 32'(MAX_ROW_PIXELS))
        begin
            w = POS_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            w = POS_W'(row_width);
        end
    end

    always_comb
    begin
        group.fill      = 1'b0;
        group.fill_col  = '0;
        group.fill_done = 1'b0;
        group.offset    = pos_reg[2:0];
        for (int i = 0; i < GROUP_PIX; i++)
        begin
            pos_i[i]  = pos_reg + POS_W'(i);
            in_row[i] = pos_i[i] < w;
            next_pos  = {1'b0, pos_i[i]} + 1'b1;
            if (in_row[i] && (pos_i[i][2:0] == 3'd7))
            begin
                group.fill      = 1'b1;
                group.fill_col  = col_of(pos_i[i]);
                group.fill_done = next_pos >= {1'b0, w};
            end
        end
        for (int p = 0; p < PLANES; p++)
        begin
            for (int i = 0; i < GROUP_PIX; i++)
            begin
                group.grp[p][2-i] = grp_raw[p][2-i] & in_row[i];
            end
        end

        end_pos           = {1'b0, pos_reg} + (POS_W+1)'(GROUP_PIX);
        group.row_end     = end_pos >= {1'b0, w};
        e                 = (pos_reg < w) ? w : pos_reg;
        group.partial     = group.row_end && (e[2:0] != 3'd0);
        group.partial_col = col_of(e);
    end

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (push)
        begin
            if (group.row_end)
            begin
                pos_next   = '0;
                phase_next = (phase == PHASE_LAST) ? 2'd0 : phase + 2'd1;
            end
            else
            begin
                pos_next   = end_pos[POS_W-1:0];
                phase_next = phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= 2'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rgbcf_queue.sv =====
// Short FIFO between the front end and the packer.
`default_nettype none

module rgbcf_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rgbcf_back.sv =====
// Packer: shifts group bits into plane bytes, holds row-end bytes, output register.
`default_nettype none

module rgbcf_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    entry_valid,
    input  rgbcf_pkg::group_t                       entry,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [rgbcf_pkg::PLANES-1:0][7:0]       out_planes,
    output logic [rgbcf_pkg::COL_W-1:0]             out_col,
    output logic                                    out_done
);
    import rgbcf_pkg::*;

    logic [PLANES-1:0][7:0] acc_reg;
    logic [PLANES-1:0][7:0] acc_next;
    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic [PLANES-1:0][7:0] hold_planes_reg;
    logic [PLANES-1:0][7:0] hold_planes_next;
    logic [COL_W-1:0]       hold_col_reg;
    logic [COL_W-1:0]       hold_col_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PLANES-1:0][7:0] out_planes_reg;
    logic [PLANES-1:0][7:0] out_planes_next;
    logic [COL_W-1:0]       out_col_reg;
    logic [COL_W-1:0]       out_col_next;
    logic                   out_done_reg;
    logic                   out_done_next;

    logic [PLANES-1:0][15:0] window;
    logic [PLANES-1:0][7:0]  hi;
    logic [PLANES-1:0][7:0]  lo;
    logic [PLANES-1:0][7:0]  tail;
    logic [3:0]              shamt;

    assign pop        = entry_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_planes = out_planes_reg;
    assign out_col    = out_col_reg;
    assign out_done   = out_done_reg;

    // hi is the byte being filled, lo the next one
    always_comb
    begin
        shamt = 4'd13 - {1'b0, entry.offset};
        for (int p = 0; p < PLANES; p++)
        begin
            window[p] = {acc_reg[p], 8'h00} | (16'(entry.grp[p]) << shamt);
            hi[p]     = window[p][15:8];
            lo[p]     = window[p][7:0];
            tail[p]   = entry.fill ? lo[p] : hi[p];
        end
    end

    always_comb
    begin
        acc_next         = acc_reg;
        hold_valid_next  = hold_valid_reg;
        hold_planes_next = hold_planes_reg;
        hold_col_next    = hold_col_reg;
        out_valid_next   = out_valid_reg;
        out_planes_next  = out_planes_reg;
        out_col_next     = out_col_reg;
        out_done_next    = out_done_reg;

        if (pop)
        begin
            acc_next         = entry.row_end ? '0 : tail;
            hold_valid_next  = entry.fill && entry.partial;
            hold_planes_next = tail;
            hold_col_next    = entry.partial_col;
            out_valid_next   = hold_valid_reg || entry.fill || entry.partial;
            priority if (hold_valid_reg)
            begin
                out_planes_next = hold_planes_reg;
                out_col_next    = hold_col_reg;
                out_done_next   = 1'b1;
            end
            else if (entry.fill)
            begin
                out_planes_next = hi;
                out_col_next    = entry.fill_col;
                out_done_next   = entry.fill_done;
            end
            else
            begin
                out_planes_next = tail;
                out_col_next    = entry.partial_col;
                out_done_next   = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_planes_reg <= hold_planes_next;
        hold_col_reg    <= hold_col_next;
        out_planes_reg  <= out_planes_next;
        out_col_reg     <= out_col_next;
        out_done_reg    <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a held byte is always followed by the first group of a row
    a_hold_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        pop && hold_valid_reg |-> !entry.fill && !entry.partial)
        else $error("held byte collides with a new byte");

    a_partial_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && entry.partial |-> entry.row_end)
        else $error("partial byte outside row end");

    a_two_bytes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pop && entry.fill && entry.partial |=> hold_valid_reg && out_valid_reg)
        else $error("second byte of a group was not held");
`endif

endmodule

`default_nettype wire

// ===== src/rgb_to_color_filter_bitplanes.sv =====
// Top level of the RGB to color filter bit plane packer.
`default_nettype none

// Accepts one group of three pixels per clock while pixel_ready is high; the
// front end computes the per-channel levels and sub-pixel bits in the cycle of
// acceptance and writes them into a two-beat queue. The packer takes one queue
// beat per cycle unless its output is stalled and loads the output register;
// a byte passes the queue and the output register. The sustained rate is one
// group per clock while the output side takes a beat every clock. The packer
// emits at most one byte per group; when the last group of a row yields both
// a full and a partial byte, the partial byte (row_done set) is kept and sent
// when the packer takes the next group. row_width is taken through its own
// always-ready channel and should only be changed while the block is idle.
module rgb_to_color_filter_bitplanes #(
    parameter int unsigned MAX_ROW_PIXELS = rgbcf_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [7:0]                          red_a,
    input  logic [7:0]                          green_a,
    input  logic [7:0]                          blue_a,
    input  logic [7:0]                          red_b,
    input  logic [7:0]                          green_b,
    input  logic [7:0]                          blue_b,
    input  logic [7:0]                          red_c,
    input  logic [7:0]                          green_c,
    input  logic [7:0]                          blue_c,
    output logic                                plane_valid,
    input  logic                                plane_ready,
    output logic [7:0]                          plane_zero,
    output logic [7:0]                          plane_one,
    output logic [7:0]                          plane_two,
    output logic [7:0]                          plane_three,
    output logic [rgbcf_pkg::COL_W-1:0]         byte_column,
    output logic                                row_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbcf_pkg::ROW_WIDTH_W-1:0]   cfg_data
);
    import rgbcf_pkg::*;

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [ROW_WIDTH_W-1:0] row_width_next;

    logic                   push;
    logic                   full;
    logic                   empty;
    logic                   pop;
    group_t                 front_group;
    group_t                 head_group;
    logic [PLANES-1:0][7:0] planes;

    assign cfg_ready   = 1'b1;
    assign pixel_ready = !full;
    assign push        = pixel_valid && !full;

    assign row_width_next = (cfg_valid && cfg_ready) ? cfg_data : row_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
        end
    end

    rgbcf_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .red_a     (red_a),
        .green_a   (green_a),
        .blue_a    (blue_a),
        .red_b     (red_b),
        .green_b   (green_b),
        .blue_b    (blue_b),
        .red_c     (red_c),
        .green_c   (green_c),
        .blue_c    (blue_c),
        .row_width (row_width_reg),
        .group     (front_group)
    );

    rgbcf_queue #(
        .WIDTH ($bits(group_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_group),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_group),
        .empty     (empty)
    );

    rgbcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (!empty),
        .entry       (head_group),
        .pop         (pop),
        .out_valid   (plane_valid),
        .out_ready   (plane_ready),
        .out_planes  (planes),
        .out_col     (byte_column),
        .out_done    (row_done)
    );

    assign plane_zero  = planes[0];
    assign plane_one   = planes[1];
    assign plane_two   = planes[2];
    assign plane_three = planes[3];

endmodule

`default_nettype wire

// ===== tb/rgbcf_plane_checker.sv =====
// Watches the pixel, plane and width channels, predicts each packed plane byte and compares.
`timescale 1ns / 100ps

module rgbcf_plane_checker #(
    parameter int unsigned MAX_ROW_PIXELS = rgbcf_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    input  logic                                pixel_ready,
    input  logic [7:0]                          red_a,
    input  logic [7:0]                          green_a,
    input  logic [7:0]                          blue_a,
    input  logic [7:0]                          red_b,
    input  logic [7:0]                          green_b,
    input  logic [7:0]                          blue_b,
    input  logic [7:0]                          red_c,
    input  logic [7:0]                          green_c,
    input  logic [7:0]                          blue_c,
    input  logic                                plane_valid,
    input  logic                                plane_ready,
    input  logic [7:0]                          plane_zero,
    input  logic [7:0]                          plane_one,
    input  logic [7:0]                          plane_two,
    input  logic [7:0]                          plane_three,
    input  logic [rgbcf_pkg::COL_W-1:0]         byte_column,
    input  logic                                row_done,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rgbcf_pkg::ROW_WIDTH_W-1:0]   cfg_data,
    output int                                  fails,
    output int                                  outstanding,
    output int                                  groups_seen,
    output int                                  bytes_seen,
    output int                                  width_writes
);

    localparam int unsigned MIN_WIDTH = 8;
    localparam logic [12:0] WIDTH_AT_RESET = 13'd1600;
    // [channel][row phase], bit 2 is the leftmost pixel of the group
    localparam logic [2:0] CHANNEL_MASK [3][3] = '{
        '{3'd2, 3'd1, 3'd4},
        '{3'd1, 3'd4, 3'd2},
        '{3'd4, 3'd2, 3'd1}
    };

    typedef logic [8:0][7:0] pixel_group_t;

    typedef struct packed {
        logic [3:0][7:0] planes;
        logic [8:0]      col;
        logic            done;
    } plane_byte_t;

    logic [12:0]     row_width_q;
    logic [3:0][7:0] acc;
    int unsigned     next_pixel;
    int unsigned     row_phase;
    bit              held;
    bit              step_emitted;
    plane_byte_t     held_byte;
    plane_byte_t     want;
    plane_byte_t     planned_bytes [$];

    // one byte per group goes out; a second one waits for the next group
    task automatic put_plane_byte(input logic [3:0][7:0] planes, input int unsigned col,
                                  input bit done);
        plane_byte_t b;
        b.planes = planes;
        b.col    = col[8:0];
        b.done   = done;
        if (!step_emitted)
        begin
            planned_bytes.push_back(b);
            step_emitted = 1'b1;
        end
        else
        begin
            held_byte = b;
            held      = 1'b1;
        end
    endtask

    task automatic pack_group(input pixel_group_t px);
        int unsigned w;
        int unsigned start;
        int unsigned pos;
        int unsigned ph;
        int unsigned sum;
        int unsigned e;
        int unsigned inv [3];
        logic [3:0][2:0] grp;
        int c;
        int p;
        int i;
        w = row_width_q;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > MAX_ROW_PIXELS)
            w = MAX_ROW_PIXELS;
        ph = (row_phase > 2) ? 0 : row_phase;
        start = next_pixel;
        step_emitted = 1'b0;
        if (held)
        begin
            held = 1'b0;
            put_plane_byte(held_byte.planes, held_byte.col, held_byte.done);
        end
        for (c = 0; c < 3; c++)
        begin
            sum = px[c] + px[3 + c] + px[6 + c];
            inv[c] = 15 - (sum / 3) / 16;
        end
        grp = '0;
        for (p = 0; p < 4; p++)
            for (c = 0; c < 3; c++)
                if (((inv[c] >> p) & 1) != 0)
                    grp[p] = grp[p] | CHANNEL_MASK[c][ph];
        for (i = 0; i < 3; i++)
        begin
            pos = start + i;
            if (pos < w)
            begin
                for (p = 0; p < 4; p++)
                    acc[p][7 - pos % 8] = acc[p][7 - pos % 8] | grp[p][2 - i];
                if (pos % 8 == 7)
                begin
                    put_plane_byte(acc, pos / 8, pos + 1 >= w);
                    acc = '0;
                end
            end
        end
        if (start + 3 >= w)
        begin
            e = (start < w) ? w : start;
            if (e % 8 != 0)
                put_plane_byte(acc, e / 8, 1'b1);
            acc = '0;
            next_pixel = 0;
            row_phase = (ph >= 2) ? 0 : ph + 1;
        end
        else
        begin
            next_pixel = start + 3;
            row_phase = ph;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            fails++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_q = WIDTH_AT_RESET;
            acc         = '0;
            next_pixel  = 0;
            row_phase   = 0;
            held        = 1'b0;
            planned_bytes.delete();
            outstanding = 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                pack_group({blue_c, green_c, red_c, blue_b, green_b, red_b,
                            blue_a, green_a, red_a});
                groups_seen++;
            end
            if (plane_valid && plane_ready)
            begin
                bytes_seen++;
                if (planned_bytes.size() == 0)
                begin
                    fails++;
                    $display("%0t ns: plane beat with none expected: %h %h %h %h col %0d done %b",
                             $time, plane_zero, plane_one, plane_two, plane_three,
                             byte_column, row_done);
                end
                else
                begin
                    want = planned_bytes.pop_front();
                    check_field("plane_zero", want.planes[0], plane_zero);
                    check_field("plane_one", want.planes[1], plane_one);
                    check_field("plane_two", want.planes[2], plane_two);
                    check_field("plane_three", want.planes[3], plane_three);
                    check_field("byte_column", want.col, byte_column);
                    check_field("row_done", want.done, row_done);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                row_width_q = cfg_data;
                width_writes++;
            end
            outstanding = planned_bytes.size();
        end
    end

endmodule

// ===== tb/rgb_to_color_filter_bitplanes_test.sv =====
// Stimulus, watchdog and verdict for the RGB to color filter bit plane block.
`timescale 1ns / 100ps

module rgb_to_color_filter_bitplanes_test;

    localparam int GROUP_TARGET       = 1600;
    localparam int IDLE_LIMIT         = 5000;
    localparam int OUTPUT_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES      = 8;
    localparam int TAIL_CYCLES        = 20;

    typedef logic [8:0][7:0] pixel_group_t;

    logic                                clk;
    logic                                rst_n;
    logic                                pixel_valid;
    logic                                pixel_ready;
    logic [7:0]                          red_a;
    logic [7:0]                          green_a;
    logic [7:0]                          blue_a;
    logic [7:0]                          red_b;
    logic [7:0]                          green_b;
    logic [7:0]                          blue_b;
    logic [7:0]                          red_c;
    logic [7:0]                          green_c;
    logic [7:0]                          blue_c;
    logic                                plane_valid;
    logic                                plane_ready;
    logic [7:0]                          plane_zero;
    logic [7:0]                          plane_one;
    logic [7:0]                          plane_two;
    logic [7:0]                          plane_three;
    logic [rgbcf_pkg::COL_W-1:0]         byte_column;
    logic                                row_done;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [rgbcf_pkg::ROW_WIDTH_W-1:0]   cfg_data;

    int fails;
    int outstanding;
    int groups_seen;
    int bytes_seen;
    int width_writes;
    int idle_cycles;
    int groups_sent;
    int long_width;
    int unsigned w;
    int k;
    bit tx_steady;
    bit rx_steady;
    bit rx_hold_request;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    rgb_to_color_filter_bitplanes i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red_a       (red_a),
        .green_a     (green_a),
        .blue_a      (blue_a),
        .red_b       (red_b),
        .green_b     (green_b),
        .blue_b      (blue_b),
        .red_c       (red_c),
        .green_c     (green_c),
        .blue_c      (blue_c),
        .plane_valid (plane_valid),
        .plane_ready (plane_ready),
        .plane_zero  (plane_zero),
        .plane_one   (plane_one),
        .plane_two   (plane_two),
        .plane_three (plane_three),
        .byte_column (byte_column),
        .row_done    (row_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    rgbcf_plane_checker u_plane_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red_a        (red_a),
        .green_a      (green_a),
        .blue_a       (blue_a),
        .red_b        (red_b),
        .green_b      (green_b),
        .blue_b       (blue_b),
        .red_c        (red_c),
        .green_c      (green_c),
        .blue_c       (blue_c),
        .plane_valid  (plane_valid),
        .plane_ready  (plane_ready),
        .plane_zero   (plane_zero),
        .plane_one    (plane_one),
        .plane_two    (plane_two),
        .plane_three  (plane_three),
        .byte_column  (byte_column),
        .row_done     (row_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .outstanding  (outstanding),
        .groups_seen  (groups_seen),
        .bytes_seen   (bytes_seen),
        .width_writes (width_writes)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic pixel_group_t make_group(
        input logic [7:0] ra, input logic [7:0] ga, input logic [7:0] ba,
        input logic [7:0] rb, input logic [7:0] gb, input logic [7:0] bb,
        input logic [7:0] rc, input logic [7:0] gc, input logic [7:0] bc);
        return {bc, gc, rc, bb, gb, rb, ba, ga, ra};
    endfunction

    function automatic pixel_group_t random_group();
        pixel_group_t g;
        int style;
        int base;
        int v;
        int c;
        int j;
        style = $urandom_range(0, 3);
        for (c = 0; c < 3; c++)
        begin
            base = $urandom_range(0, 255);
            for (j = 0; j < 3; j++)
            begin
                case (style)
                    0: v = $urandom_range(0, 255);
                    1: v = base + int'($urandom_range(0, 16)) - 8;
                    2: v = $urandom_range(0, 1) ? 255 : 0;
                    default: v = base;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                g[3 * j + c] = v[7:0];
            end
        end
        return g;
    endfunction

    // channel extremes and level boundaries
    function automatic pixel_group_t directed_group(input int n);
        case (n)
            0: return make_group(0, 0, 0, 0, 0, 0, 0, 0, 0);
            1: return make_group(255, 255, 255, 255, 255, 255, 255, 255, 255);
            2: return make_group(255, 0, 0, 255, 0, 0, 255, 0, 0);
            3: return make_group(0, 255, 0, 0, 255, 0, 0, 255, 0);
            4: return make_group(0, 0, 255, 0, 0, 255, 0, 0, 255);
            5: return make_group(15, 16, 240, 15, 16, 240, 15, 16, 240);
            6: return make_group(255, 0, 127, 254, 0, 128, 254, 2, 128);
            7: return make_group(8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0, 8'hAA, 8'h55, 8'h0F);
            default: return random_group();
        endcase
    endfunction

    function automatic int phase_length(input int unsigned width);
        int unsigned wc;
        int unsigned per_row;
        wc = (width < 8) ? 8 : ((width > 4096) ? 4096 : width);
        per_row = (wc + 2) / 3;
        if (wc <= 40)
            return $urandom_range(1, 4) * per_row + $urandom_range(0, per_row - 1);
        if (wc <= 400)
            return per_row + $urandom_range(0, per_row - 1);
        return $urandom_range(20, 100);
    endfunction

    task automatic send_group(input pixel_group_t g);
        int gap;
        gap = (tx_steady || $urandom_range(0, 99) < 65) ? 0 : gap_length();
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        red_a       <= g[0];
        green_a     <= g[1];
        blue_a      <= g[2];
        red_b       <= g[3];
        green_b     <= g[4];
        blue_b      <= g[5];
        red_c       <= g[6];
        green_c     <= g[7];
        blue_c      <= g[8];
        do
            @(posedge clk);
        while (!pixel_ready);
        groups_sent++;
    endtask

    task automatic drain_planes();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_width(input int unsigned width);
        drain_planes();
        cfg_valid <= 1'b1;
        cfg_data  <= width[rgbcf_pkg::ROW_WIDTH_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned width, input int n);
        write_width(width);
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        repeat (n) send_group(random_group());
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (plane_valid && plane_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side
    initial
    begin
        plane_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                plane_ready <= 1'b0;
                repeat (OUTPUT_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_steady || $urandom_range(0, 99) < 70)
                plane_ready <= 1'b1;
            else
            begin
                plane_ready <= 1'b0;
                repeat (gap_length() - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        red_a       = '0;
        green_a     = '0;
        blue_a      = '0;
        red_b       = '0;
        green_b     = '0;
        blue_b      = '0;
        red_c       = '0;
        green_c     = '0;
        blue_c      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        groups_sent = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_request = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset width, then a shrink with nothing pending
        for (k = 0; k < 8; k++)
            send_group(directed_group(k));
        write_width(0);
        repeat (4) send_group(random_group());
        // last group fills one byte and leaves a partial one
        write_width(9);
        repeat (4) send_group(random_group());
        write_width(13'h1FFF);
        repeat (6) send_group(random_group());
        // shrink mid-row with a partial byte pending
        write_width(5);
        send_group(random_group());

        // output held off while the input keeps offering
        write_width(20);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        rx_hold_request = 1'b1;
        repeat (60) send_group(random_group());

        run_phase(8, phase_length(8));
        run_phase(4096, 60);
        run_phase(8191, 40);
        long_width = $urandom_range(2100, 2300);
        run_phase(long_width, (long_width + 2) / 3 + $urandom_range(1, 6));

        while (groups_sent < GROUP_TARGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
                w = $urandom_range(0, 7);
            else if (k < 70)
                w = $urandom_range(8, 40);
            else if (k < 85)
                w = $urandom_range(41, 400);
            else if (k < 90)
                w = 4096;
            else if (k < 95)
                w = $urandom_range(4097, 8191);
            else
                w = $urandom_range(401, 4095);
            run_phase(w, phase_length(w));
        end

        drain_planes();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("tb: %0d pixel groups, %0d plane beats, %0d row_width writes",
                 groups_seen, bytes_seen, width_writes);
        $display("tb: widths under 8 and over 4096, a %0d-pixel row, mid-row shrinks, %0d-cycle hold-off",
                 long_width, OUTPUT_HOLD_CYCLES);
        if (fails == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
